[sv/ssc_pkg.sv]
// Shared types and constants for the two-axis servo slew controller.
// Holds field widths, reset calibration, command and register codes, and lane structs.
// No dependencies; compile first.
package ssc_pkg;

   localparam int PULSE_W    = 12;
   localparam int POS_W      = 11;
   localparam int POS_MAG_W  = 10;
   localparam int POS_SCALE  = 1000;
   localparam int IN_POS_W   = 16;
   localparam int STEP_W     = 8;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int NUM_W      = PULSE_W + POS_MAG_W;
   localparam int DEN_W      = PULSE_W;

   localparam logic [PULSE_W-1:0] H_NEG_RST = 12'd1000;
   localparam logic [PULSE_W-1:0] H_CTR_RST = 12'd1248;
   localparam logic [PULSE_W-1:0] H_POS_RST = 12'd1500;
   localparam logic [PULSE_W-1:0] P_NEG_RST = 12'd1200;
   localparam logic [PULSE_W-1:0] P_CTR_RST = 12'd1450;
   localparam logic [PULSE_W-1:0] P_POS_RST = 12'd1830;
   localparam logic [STEP_W-1:0]  STEP_RST  = 8'd1;

   localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(POS_SCALE);
   localparam logic signed [POS_W-1:0] POS_MIN = -POS_MAX;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK   = 2'd0,
      CMD_TARGET = 2'd1,
      CMD_IMMED  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_H_NEG = 3'd0,
      CSR_H_CTR = 3'd1,
      CSR_H_POS = 3'd2,
      CSR_P_NEG = 3'd3,
      CSR_P_CTR = 3'd4,
      CSR_P_POS = 3'd5,
      CSR_STEP  = 3'd6
   } csr_idx_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RUN,
      S_CHECK,
      S_WAIT,
      S_DONE
   } top_state_type;

   typedef enum logic [1:0] {
      LS_IDLE,
      LS_MUL,
      LS_DIV
   } lane_state_type;

   typedef enum logic [2:0] {
      LOP_SLEW,
      LOP_COPY,
      LOP_TARGET,
      LOP_IMMED,
      LOP_POSN
   } lane_op_type;

   typedef struct packed {
      logic [PULSE_W-1:0] neg;
      logic [PULSE_W-1:0] ctr;
      logic [PULSE_W-1:0] posl;
      logic [STEP_W-1:0]  step;
   } lane_cfg_type;

   typedef struct packed {
      logic                    start;
      lane_op_type             op;
      logic signed [POS_W-1:0] pos;
   } lane_cmd_type;

   typedef struct packed {
      logic                    busy;
      logic [PULSE_W-1:0]      pulse;
      logic [PULSE_W-1:0]      target;
      logic signed [POS_W-1:0] now;
      logic signed [POS_W-1:0] goal;
   } lane_sts_type;

endpackage

[sv/ssc_if.sv]
// Request and response channel interfaces for the servo slew controller.
// Each carries valid, ready and the word payload; widths come from ssc_pkg.
interface ssc_req_if;
   import ssc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           cmd;
   logic signed [IN_POS_W-1:0] horizontal_position;
   logic signed [IN_POS_W-1:0] pitch_position;

   modport source (output valid, output cmd, output horizontal_position,
                   output pitch_position, input ready);
   modport sink   (input valid, input cmd, input horizontal_position,
                   input pitch_position, output ready);
endinterface

interface ssc_rsp_if;
   import ssc_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [PULSE_W-1:0]      horizontal_pulse_out;
   logic [PULSE_W-1:0]      pitch_pulse_out;
   logic                    horizontal_changed;
   logic                    pitch_changed;
   logic signed [POS_W-1:0] current_horizontal;
   logic signed [POS_W-1:0] current_pitch;
   logic signed [POS_W-1:0] target_horizontal;
   logic signed [POS_W-1:0] target_pitch;
   logic                    both_on_target;

   modport source (output valid, output horizontal_pulse_out, output pitch_pulse_out,
                   output horizontal_changed, output pitch_changed,
                   output current_horizontal, output current_pitch,
                   output target_horizontal, output target_pitch,
                   output both_on_target, input ready);
   modport sink   (input valid, input horizontal_pulse_out, input pitch_pulse_out,
                   input horizontal_changed, input pitch_changed,
                   input current_horizontal, input current_pitch,
                   input target_horizontal, input target_pitch,
                   input both_on_target, output ready);
endinterface

[sv/ssc_div.sv]
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on ssc_pkg for the numerator and divisor widths.
module ssc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ssc_pkg::NUM_W-1:0]   numer,
   input  logic [ssc_pkg::DEN_W-1:0]   denom,
   output logic                        busy,
   output logic [ssc_pkg::NUM_W-1:0]   quotient
);
   import ssc_pkg::*;

   localparam int DIV_STEPS = NUM_W / 2;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W+NUM_W-1:0] first, second;

   // One restoring step: shift in the next numerator bit, subtract if it fits.
   function automatic logic [DEN_W+NUM_W-1:0] div_step(
      input logic [DEN_W-1:0] r,
      input logic [NUM_W-1:0] q,
      input logic [DEN_W-1:0] d
   );
      logic [DEN_W:0] t;
      logic           fits;
      t    = {r, q[NUM_W-1]};
      fits = (t >= {1'b0, d});
      if (fits) begin
         t = t - {1'b0, d};
      end
      return {t[DEN_W-1:0], q[NUM_W-2:0], fits};
   endfunction

   always_comb begin
      first  = div_step(rem_ff, quo_ff, den_ff);
      second = div_step(first[DEN_W+NUM_W-1:NUM_W], first[NUM_W-1:0], den_ff);
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = second[DEN_W+NUM_W-1:NUM_W];
         quo_in = second[NUM_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[sv/ssc_lane.sv]
// One servo axis lane: pulse slew, position-to-pulse mapping and pulse-to-position report.
// Depends on ssc_pkg and ssc_div; one multiplier feeds the lane's own divider.
module ssc_lane #(
   parameter logic [ssc_pkg::PULSE_W-1:0] RESET_PULSE = ssc_pkg::H_CTR_RST
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ssc_pkg::lane_cfg_type cfg,
   input  ssc_pkg::lane_cmd_type cmd,
   output ssc_pkg::lane_sts_type sts
);
   import ssc_pkg::*;

   localparam int SUM_W = PULSE_W + 2;

   lane_state_type          state_ff, state_in;
   lane_op_type             op_ff, op_in;
   logic [PULSE_W-1:0]      pulse_ff, pulse_in;
   logic [PULSE_W-1:0]      target_ff, target_in;
   logic signed [POS_W-1:0] now_ff, now_in;
   logic signed [POS_W-1:0] goal_ff, goal_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic                    neg_side_ff, neg_side_in;
   logic                    span_neg_ff, span_neg_in;
   logic [PULSE_W-1:0]      mul_a_ff, mul_a_in;
   logic [POS_MAG_W-1:0]    mul_b_ff, mul_b_in;
   logic [DEN_W-1:0]        den_ff, den_in;

   logic signed [PULSE_W:0] span_lo, span_hi, span_sel;
   logic [PULSE_W-1:0]      span_mag, diff, step_eff, slew_next;
   logic [POS_MAG_W-1:0]    pos_mag, pos_fit;
   logic                    pos_neg, pulse_low, side, go_div;
   logic                    div_start, div_busy, finish, add_dir;
   logic [NUM_W-1:0]        numer, quotient;
   logic signed [SUM_W-1:0] sum;
   logic [PULSE_W-1:0]      pulse_fit;
   logic signed [POS_W-1:0] pos_result;

   assign span_lo   = $signed({1'b0, cfg.ctr}) - $signed({1'b0, cfg.neg});
   assign span_hi   = $signed({1'b0, cfg.posl}) - $signed({1'b0, cfg.ctr});
   assign pos_neg   = cmd.pos[POS_W-1];
   assign pulse_low = (pulse_ff < cfg.ctr);
   assign pos_mag   = pos_neg ? POS_MAG_W'(-cmd.pos) : POS_MAG_W'(cmd.pos);

   // The side of center picks the calibration span in both directions of mapping.
   always_comb begin
      side     = (cmd.op == LOP_POSN) ? pulse_low : pos_neg;
      span_sel = side ? span_lo : span_hi;
      span_mag = span_sel[PULSE_W] ? PULSE_W'(-span_sel) : PULSE_W'(span_sel);
      diff     = pulse_low ? (cfg.ctr - pulse_ff) : (pulse_ff - cfg.ctr);
      go_div   = cmd.start && ((cmd.op == LOP_TARGET) || (cmd.op == LOP_IMMED) ||
                               ((cmd.op == LOP_POSN) && (span_mag != '0)));
   end

   always_comb begin
      step_eff = (cfg.step == '0) ? PULSE_W'(1) : PULSE_W'(cfg.step);
      if (pulse_ff < target_ff) begin
         slew_next = ((target_ff - pulse_ff) <= step_eff) ? target_ff : pulse_ff + step_eff;
      end else if (pulse_ff > target_ff) begin
         slew_next = ((pulse_ff - target_ff) <= step_eff) ? target_ff : pulse_ff - step_eff;
      end else begin
         slew_next = pulse_ff;
      end
   end

   // Quotient magnitudes get their sign back from the side and the span direction.
   always_comb begin
      add_dir = neg_side_ff ? span_neg_ff : !span_neg_ff;
      if (add_dir) begin
         sum = $signed({2'b00, cfg.ctr}) + $signed({2'b00, quotient[PULSE_W-1:0]});
      end else begin
         sum = $signed({2'b00, cfg.ctr}) - $signed({2'b00, quotient[PULSE_W-1:0]});
      end
      if (sum[SUM_W-1]) begin
         pulse_fit = '0;
      end else if (sum[PULSE_W]) begin
         pulse_fit = '1;
      end else begin
         pulse_fit = sum[PULSE_W-1:0];
      end
      pos_fit = (quotient > NUM_W'(POS_SCALE)) ? POS_MAG_W'(POS_SCALE)
                                              : quotient[POS_MAG_W-1:0];
      pos_result = (neg_side_ff ^ span_neg_ff) ? -$signed({1'b0, pos_fit})
                                              : $signed({1'b0, pos_fit});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LS_IDLE: begin
            if (go_div) begin
               state_in = LS_MUL;
            end
         end
         LS_MUL: begin
            state_in = LS_DIV;
         end
         LS_DIV: begin
            if (!div_busy) begin
               state_in = LS_IDLE;
            end
         end
         default: begin
            state_in = LS_IDLE;
         end
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      finish    = 1'b0;
      unique case (state_ff)
         LS_MUL:  div_start = 1'b1;
         LS_DIV:  finish    = !div_busy;
         default: ;
      endcase
   end

   always_comb begin
      op_in       = op_ff;
      pulse_in    = pulse_ff;
      target_in   = target_ff;
      now_in      = now_ff;
      goal_in     = goal_ff;
      pos_in      = pos_ff;
      neg_side_in = neg_side_ff;
      span_neg_in = span_neg_ff;
      mul_a_in    = mul_a_ff;
      mul_b_in    = mul_b_ff;
      den_in      = den_ff;
      if (cmd.start) begin
         op_in       = cmd.op;
         pos_in      = cmd.pos;
         neg_side_in = side;
         span_neg_in = span_sel[PULSE_W];
         if (cmd.op == LOP_POSN) begin
            mul_a_in = diff;
            mul_b_in = POS_MAG_W'(POS_SCALE);
            den_in   = span_mag;
         end else begin
            mul_a_in = span_mag;
            mul_b_in = pos_mag;
            den_in   = DEN_W'(POS_SCALE);
         end
         case (cmd.op)
            LOP_SLEW: pulse_in = slew_next;
            LOP_COPY: now_in   = goal_ff;
            LOP_POSN: begin
               if (span_mag == '0) begin
                  now_in = '0;
               end
            end
            default: ;
         endcase
      end
      if (finish) begin
         case (op_ff)
            LOP_TARGET: begin
               target_in = pulse_fit;
               goal_in   = pos_ff;
            end
            LOP_IMMED: begin
               pulse_in  = pulse_fit;
               target_in = pulse_fit;
               now_in    = pos_ff;
               goal_in   = pos_ff;
            end
            LOP_POSN: now_in = pos_result;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= LS_IDLE;
         pulse_ff  <= RESET_PULSE;
         target_ff <= RESET_PULSE;
         now_ff    <= '0;
         goal_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         pulse_ff  <= pulse_in;
         target_ff <= target_in;
         now_ff    <= now_in;
         goal_ff   <= goal_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pos_ff      <= pos_in;
      neg_side_ff <= neg_side_in;
      span_neg_ff <= span_neg_in;
      mul_a_ff    <= mul_a_in;
      mul_b_ff    <= mul_b_in;
      den_ff      <= den_in;
   end

   assign numer = mul_a_ff * mul_b_ff;

   ssc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .denom    (den_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign sts.busy   = (state_ff != LS_IDLE);
   assign sts.pulse  = pulse_ff;
   assign sts.target = target_ff;
   assign sts.now    = now_ff;
   assign sts.goal   = goal_ff;

endmodule

[sv/two_axis_servo_slew_controller_core.sv]
// Channel   Dir  Handshake              Word
// req_if    in   valid/ready            cmd, horizontal_position, pitch_position
// rsp_if    out  valid/ready            pulses, changed flags, positions, targets, reached
// csr_*     in   csr_we, no wait        csr_index selects one of seven calibration registers
// A word goes from the run state to the wait state, by way of the check state for a tick,
// and then to the done state; an unused command code goes from run straight to done.
// Set-target, set-immediate and a tick that leaves an axis moving spend the wait state
// on the two-bit-per-cycle divider in each axis lane.
// Reset is synchronous; calibration returns to its defaults and both pulses to center.
// A stalled response holds the next word in the done state; a new request is taken
// while an earlier response still waits.
module two_axis_servo_slew_controller_core (
   input  logic                             clock,
   input  logic                             reset,
   ssc_req_if.sink                          req_if,
   ssc_rsp_if.source                        rsp_if,
   input  logic                             csr_we,
   input  logic [ssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ssc_pkg::*;

   localparam logic signed [IN_POS_W-1:0] IN_POS_MAX = IN_POS_W'(POS_SCALE);

   logic [PULSE_W-1:0] h_neg_ff, h_ctr_ff, h_pos_ff;
   logic [PULSE_W-1:0] p_neg_ff, p_ctr_ff, p_pos_ff;
   logic [STEP_W-1:0]  step_ff;

   top_state_type           state_ff, state_in;
   cmd_type                 cmd_ff;
   logic signed [POS_W-1:0] hreq_ff, preq_ff;
   logic [PULSE_W-1:0]      old_h_ff, old_p_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]      rsp_h_pulse_ff, rsp_p_pulse_ff;
   logic                    rsp_h_chg_ff, rsp_p_chg_ff, rsp_reached_ff;
   logic signed [POS_W-1:0] rsp_h_now_ff, rsp_p_now_ff, rsp_h_goal_ff, rsp_p_goal_ff;

   logic         accept, load_rsp, lane_start, reached;
   lane_op_type  lane_op;
   lane_cfg_type h_cfg, p_cfg;
   lane_cmd_type h_cmd, p_cmd;
   lane_sts_type h_sts, p_sts;

   function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [IN_POS_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > IN_POS_MAX) begin
         r = POS_MAX;
      end else if (v < -IN_POS_MAX) begin
         r = POS_MIN;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         h_neg_ff <= H_NEG_RST;
         h_ctr_ff <= H_CTR_RST;
         h_pos_ff <= H_POS_RST;
         p_neg_ff <= P_NEG_RST;
         p_ctr_ff <= P_CTR_RST;
         p_pos_ff <= P_POS_RST;
         step_ff  <= STEP_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_H_NEG: h_neg_ff <= csr_wdata[PULSE_W-1:0];
            CSR_H_CTR: h_ctr_ff <= csr_wdata[PULSE_W-1:0];
            CSR_H_POS: h_pos_ff <= csr_wdata[PULSE_W-1:0];
            CSR_P_NEG: p_neg_ff <= csr_wdata[PULSE_W-1:0];
            CSR_P_CTR: p_ctr_ff <= csr_wdata[PULSE_W-1:0];
            CSR_P_POS: p_pos_ff <= csr_wdata[PULSE_W-1:0];
            CSR_STEP:  step_ff  <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   assign h_cfg = '{neg: h_neg_ff, ctr: h_ctr_ff, posl: h_pos_ff, step: step_ff};
   assign p_cfg = '{neg: p_neg_ff, ctr: p_ctr_ff, posl: p_pos_ff, step: step_ff};

   assign accept  = req_if.valid && req_if.ready;
   assign reached = (h_sts.pulse == h_sts.target) && (p_sts.pulse == p_sts.target);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            case (cmd_ff)
               CMD_TICK:   state_in = S_CHECK;
               CMD_TARGET: state_in = S_WAIT;
               CMD_IMMED:  state_in = S_WAIT;
               default:    state_in = S_DONE;
            endcase
         end
         S_CHECK: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (!h_sts.busy && !p_sts.busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_if.ready = 1'b0;
      lane_start   = 1'b0;
      lane_op      = LOP_SLEW;
      load_rsp     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
         end
         S_RUN: begin
            case (cmd_ff)
               CMD_TICK: begin
                  lane_start = 1'b1;
                  lane_op    = LOP_SLEW;
               end
               CMD_TARGET: begin
                  lane_start = 1'b1;
                  lane_op    = LOP_TARGET;
               end
               CMD_IMMED: begin
                  lane_start = 1'b1;
                  lane_op    = LOP_IMMED;
               end
               default: ;
            endcase
         end
         S_CHECK: begin
            // Once both axes arrive the stored goals are reported exactly.
            lane_start = 1'b1;
            lane_op    = reached ? LOP_COPY : LOP_POSN;
         end
         S_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_if.ready;
         end
         default: ;
      endcase
   end

   assign h_cmd = '{start: lane_start, op: lane_op, pos: hreq_ff};
   assign p_cmd = '{start: lane_start, op: lane_op, pos: preq_ff};

   ssc_lane #(.RESET_PULSE(H_CTR_RST)) u_lane_h (
      .clock (clock),
      .reset (reset),
      .cfg   (h_cfg),
      .cmd   (h_cmd),
      .sts   (h_sts)
   );

   ssc_lane #(.RESET_PULSE(P_CTR_RST)) u_lane_p (
      .clock (clock),
      .reset (reset),
      .cfg   (p_cfg),
      .cmd   (p_cmd),
      .sts   (p_sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_if.cmd);
         hreq_ff  <= clamp_pos(req_if.horizontal_position);
         preq_ff  <= clamp_pos(req_if.pitch_position);
         old_h_ff <= h_sts.pulse;
         old_p_ff <= p_sts.pulse;
      end
      if (load_rsp) begin
         rsp_h_pulse_ff <= h_sts.pulse;
         rsp_p_pulse_ff <= p_sts.pulse;
         rsp_h_chg_ff   <= (h_sts.pulse != old_h_ff);
         rsp_p_chg_ff   <= (p_sts.pulse != old_p_ff);
         rsp_h_now_ff   <= h_sts.now;
         rsp_p_now_ff   <= p_sts.now;
         rsp_h_goal_ff  <= h_sts.goal;
         rsp_p_goal_ff  <= p_sts.goal;
         rsp_reached_ff <= reached;
      end
   end

   assign rsp_if.valid                = rsp_valid_ff;
   assign rsp_if.horizontal_pulse_out = rsp_h_pulse_ff;
   assign rsp_if.pitch_pulse_out      = rsp_p_pulse_ff;
   assign rsp_if.horizontal_changed   = rsp_h_chg_ff;
   assign rsp_if.pitch_changed        = rsp_p_chg_ff;
   assign rsp_if.current_horizontal   = rsp_h_now_ff;
   assign rsp_if.current_pitch        = rsp_p_now_ff;
   assign rsp_if.target_horizontal    = rsp_h_goal_ff;
   assign rsp_if.target_pitch         = rsp_p_goal_ff;
   assign rsp_if.both_on_target       = rsp_reached_ff;

`ifndef SYNTHESIS
   a_one_word_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("request taken while a word was still in work");

   a_lanes_busy_only_in_wait: assert property (@(posedge clock) disable iff (reset)
      (h_sts.busy || p_sts.busy) |-> (state_ff == S_WAIT))
      else $error("lane divider running outside the wait state");

   a_done_loads_free_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished word not moved into a free response register");

   a_target_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_h_goal_ff <= POS_MAX && rsp_h_goal_ff >= POS_MIN &&
                        rsp_p_goal_ff <= POS_MAX && rsp_p_goal_ff >= POS_MIN))
      else $error("stored target position outside the clamp range");
`endif

endmodule

[dv/tb_two_axis_servo_slew_controller_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the two-axis servo slew controller core.
// Drives request words and calibration writes, predicts every response word and checks it.
// Depends on ssc_pkg, the channel interfaces and the core itself.
module tb_two_axis_servo_slew_controller_core;
   import ssc_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic [PULSE_W-1:0]      h_pw;
      logic [PULSE_W-1:0]      p_pw;
      logic                    h_moved;
      logic                    p_moved;
      logic signed [POS_W-1:0] h_now;
      logic signed [POS_W-1:0] p_now;
      logic signed [POS_W-1:0] h_goal;
      logic signed [POS_W-1:0] p_goal;
      logic                    reached;
   } servo_word_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   ssc_req_if req_ch ();
   ssc_rsp_if rsp_ch ();

   two_axis_servo_slew_controller_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted servo state and calibration.
   int cal_reg [0:6];
   int h_pw, p_pw, h_pw_target, p_pw_target;
   int h_now, p_now, h_goal, p_goal;

   servo_word_type pending_servo_words [$];
   int mismatch_count = 0;
   int word_count = 0;
   int send_idle_pct = 0;
   int rcv_idle_pct = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int clamp_permille(int p);
      if (p < -POS_SCALE) return -POS_SCALE;
      if (p > POS_SCALE) return POS_SCALE;
      return p;
   endfunction

   function automatic int permille_to_pulse(int p, int neg, int ctr, int posl);
      int r;
      p = clamp_permille(p);
      if (p < 0) r = ctr - ((-p) * (ctr - neg)) / POS_SCALE;
      else r = ctr + (p * (posl - ctr)) / POS_SCALE;
      if (r < 0) r = 0;
      if (r > (1 << PULSE_W) - 1) r = (1 << PULSE_W) - 1;
      return r;
   endfunction

   // A zero span on the side the pulse falls on reports position 0.
   function automatic int pulse_to_permille(int pw, int neg, int ctr, int posl);
      int span;
      int q;
      if (pw < ctr) begin
         span = ctr - neg;
         if (span == 0) return 0;
         q = -(((ctr - pw) * POS_SCALE) / span);
      end else begin
         span = posl - ctr;
         if (span == 0) return 0;
         q = ((pw - ctr) * POS_SCALE) / span;
      end
      return clamp_permille(q);
   endfunction

   function automatic int slew_toward(int cur, int tgt, int stride);
      if (cur < tgt) return (tgt - cur <= stride) ? tgt : cur + stride;
      if (cur > tgt) return (cur - tgt <= stride) ? tgt : cur - stride;
      return cur;
   endfunction

   function automatic bit servo_arrived();
      return (h_pw == h_pw_target) && (p_pw == p_pw_target);
   endfunction

   function automatic servo_word_type predict_servo_word(logic [CMD_W-1:0] cmd,
                                                         logic signed [IN_POS_W-1:0] h_in,
                                                         logic signed [IN_POS_W-1:0] p_in);
      servo_word_type w;
      int h_req, p_req, h_old, p_old, stride;
      h_req = clamp_permille(h_in);
      p_req = clamp_permille(p_in);
      h_old = h_pw;
      p_old = p_pw;
      stride = (cal_reg[CSR_STEP] == 0) ? 1 : cal_reg[CSR_STEP];
      case (cmd)
         CMD_TICK: begin
            h_pw = slew_toward(h_pw, h_pw_target, stride);
            p_pw = slew_toward(p_pw, p_pw_target, stride);
            if (servo_arrived()) begin
               h_now = h_goal;
               p_now = p_goal;
            end else begin
               h_now = pulse_to_permille(h_pw, cal_reg[CSR_H_NEG], cal_reg[CSR_H_CTR],
                                         cal_reg[CSR_H_POS]);
               p_now = pulse_to_permille(p_pw, cal_reg[CSR_P_NEG], cal_reg[CSR_P_CTR],
                                         cal_reg[CSR_P_POS]);
            end
         end
         CMD_TARGET: begin
            h_goal = h_req;
            p_goal = p_req;
            h_pw_target = permille_to_pulse(h_req, cal_reg[CSR_H_NEG], cal_reg[CSR_H_CTR],
                                            cal_reg[CSR_H_POS]);
            p_pw_target = permille_to_pulse(p_req, cal_reg[CSR_P_NEG], cal_reg[CSR_P_CTR],
                                            cal_reg[CSR_P_POS]);
         end
         CMD_IMMED: begin
            h_pw = permille_to_pulse(h_req, cal_reg[CSR_H_NEG], cal_reg[CSR_H_CTR],
                                     cal_reg[CSR_H_POS]);
            p_pw = permille_to_pulse(p_req, cal_reg[CSR_P_NEG], cal_reg[CSR_P_CTR],
                                     cal_reg[CSR_P_POS]);
            h_pw_target = h_pw;
            p_pw_target = p_pw;
            h_now = h_req;
            p_now = p_req;
            h_goal = h_req;
            p_goal = p_req;
         end
         default: ;
      endcase
      w.h_pw    = h_pw[PULSE_W-1:0];
      w.p_pw    = p_pw[PULSE_W-1:0];
      w.h_moved = (h_pw != h_old);
      w.p_moved = (p_pw != p_old);
      w.h_now   = h_now[POS_W-1:0];
      w.p_now   = p_now[POS_W-1:0];
      w.h_goal  = h_goal[POS_W-1:0];
      w.p_goal  = p_goal[POS_W-1:0];
      w.reached = servo_arrived();
      return w;
   endfunction

   task automatic check_field(string name, logic signed [15:0] want, logic signed [15:0] got);
      if (got !== want) begin
         if (mismatch_count < 10)
            $display("word %0d field %s: expected %0d, got %0d", word_count, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      servo_word_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_servo_words.size() == 0) begin
            if (mismatch_count < 10)
               $display("word %0d arrived with no request outstanding", word_count);
            mismatch_count++;
         end else begin
            want = pending_servo_words.pop_front();
            check_field("horizontal_pulse_out", want.h_pw, rsp_ch.horizontal_pulse_out);
            check_field("pitch_pulse_out", want.p_pw, rsp_ch.pitch_pulse_out);
            check_field("horizontal_changed", want.h_moved, rsp_ch.horizontal_changed);
            check_field("pitch_changed", want.p_moved, rsp_ch.pitch_changed);
            check_field("current_horizontal", want.h_now, rsp_ch.current_horizontal);
            check_field("current_pitch", want.p_now, rsp_ch.current_pitch);
            check_field("target_horizontal", want.h_goal, rsp_ch.target_horizontal);
            check_field("target_pitch", want.p_goal, rsp_ch.target_pitch);
            check_field("both_on_target", want.reached, rsp_ch.both_on_target);
         end
         word_count++;
      end
   end

   task automatic send_word(logic [CMD_W-1:0] cmd, logic signed [IN_POS_W-1:0] h_in,
                            logic signed [IN_POS_W-1:0] p_in);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid               <= 1'b1;
      req_ch.cmd                 <= cmd;
      req_ch.horizontal_position <= h_in;
      req_ch.pitch_position      <= p_in;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pending_servo_words.push_back(predict_servo_word(cmd, h_in, p_in));
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_servo_words.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_STEP) cal_reg[idx] = data[STEP_W-1:0];
      else if (idx <= CSR_P_POS) cal_reg[idx] = data;
   endtask

   task automatic set_calibration(int hn, int hc, int hp, int pn, int pc, int pp, int stride);
      drain_results();
      write_reg(CSR_H_NEG, CSR_DATA_W'(hn));
      write_reg(CSR_H_CTR, CSR_DATA_W'(hc));
      write_reg(CSR_H_POS, CSR_DATA_W'(hp));
      write_reg(CSR_P_NEG, CSR_DATA_W'(pn));
      write_reg(CSR_P_CTR, CSR_DATA_W'(pc));
      write_reg(CSR_P_POS, CSR_DATA_W'(pp));
      write_reg(CSR_STEP, CSR_DATA_W'(stride));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly in range, some near the current goal, some at the clamp edges, some raw.
   function automatic logic signed [IN_POS_W-1:0] pick_position(int near);
      int sel;
      int r;
      sel = $urandom_range(99);
      if (sel < 50) begin
         r = int'($urandom_range(2000)) - 1000;
      end else if (sel < 65) begin
         r = near + int'($urandom_range(20)) - 10;
      end else if (sel < 80) begin
         case ($urandom_range(6))
            0: r = -1000;
            1: r = 1000;
            2: r = -1001;
            3: r = 1001;
            4: r = 1;
            5: r = -1;
            default: r = 0;
         endcase
      end else begin
         r = int'($urandom());
      end
      return IN_POS_W'(r);
   endfunction

   task automatic run_random(int n);
      int sent;
      int ticks;
      int roll;
      sent = 0;
      while (sent < n) begin
         roll = $urandom_range(99);
         if (roll < 80) begin
            if (roll < 20) begin
               send_word(CMD_IMMED, pick_position(h_goal), pick_position(p_goal));
               sent++;
            end
            send_word(CMD_TARGET, pick_position(h_goal), pick_position(p_goal));
            sent++;
            ticks = $urandom_range(80, 2);
            while (ticks > 0) begin
               send_word(CMD_TICK, IN_POS_W'($urandom()), IN_POS_W'($urandom()));
               sent++;
               ticks--;
               // One more tick once arrived, to see the goal copied again.
               if (servo_arrived() && ticks > 1) ticks = 1;
            end
         end else begin
            send_word(CMD_W'($urandom_range(3)), IN_POS_W'($urandom()),
                      IN_POS_W'($urandom()));
            sent++;
         end
      end
   endtask

   task automatic test_directed_edges();
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_SPARE, 16'sh7FFF, 16'sh8000);
      send_word(CMD_TARGET, 16'sh7FFF, 16'sh8000);
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_TICK, -1, -1);
      send_word(CMD_IMMED, -1000, 1000);
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_TARGET, -1001, 1001);
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_IMMED, 0, 0);
      // Targets so close that the pulse does not change at all.
      send_word(CMD_TARGET, 1, -1);
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_IMMED, 1001, -1001);
      send_word(CMD_TARGET, -1000, 1000);
      send_word(CMD_TICK, 0, 0);
      send_word(CMD_SPARE, -1, 0);
      send_word(CMD_IMMED, 16'sh8000, 16'sh7FFF);
      send_word(CMD_TARGET, 999, -999);
      send_word(CMD_TICK, 16'sh7FFF, 16'sh8000);
      send_word(CMD_TICK, 0, 0);
   endtask

   task automatic test_default_calibration();
      run_random(250);
   endtask

   task automatic test_extreme_calibration();
      set_calibration(0, 0, 0, 0, 0, 0, 255);
      run_random(120);
      set_calibration(4095, 4095, 4095, 4095, 4095, 4095, 1);
      run_random(80);
      set_calibration(0, 2048, 4095, 4095, 2048, 0, 16);
      run_random(120);
      // Zero span on one side of center only.
      set_calibration(1500, 1500, 2500, 500, 3000, 3000, 9);
      run_random(120);
   endtask

   task automatic test_reversed_calibration();
      set_calibration(2000, 1500, 1000, 3000, 1000, 200, 7);
      run_random(150);
      set_calibration(4095, 0, 4095, 0, 4095, 0, 200);
      run_random(150);
   endtask

   task automatic test_step_sizes();
      // The low byte is zero here, which must behave as a step of one.
      set_calibration(1000, 1248, 1500, 1200, 1450, 1830, 12'hF00);
      run_random(100);
      set_calibration(1000, 1248, 1500, 1200, 1450, 1830, 255);
      run_random(100);
      set_calibration(1000, 1248, 1500, 1200, 1450, 1830, 12'hAFF);
      run_random(80);
   endtask

   task automatic test_random_calibration();
      repeat (3) begin
         set_calibration($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095));
         run_random(80);
      end
   endtask

   task automatic test_unused_register_index();
      drain_results();
      write_reg(CSR_SPARE, CSR_DATA_W'($urandom()));
      write_reg(CSR_SPARE, 12'hFFF);
      @(negedge clock);
      csr_we <= 1'b0;
      run_random(60);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.horizontal_position = '0;
      req_ch.pitch_position = '0;
      rsp_ch.ready = 1'b0;
      cal_reg[CSR_H_NEG] = H_NEG_RST;
      cal_reg[CSR_H_CTR] = H_CTR_RST;
      cal_reg[CSR_H_POS] = H_POS_RST;
      cal_reg[CSR_P_NEG] = P_NEG_RST;
      cal_reg[CSR_P_CTR] = P_CTR_RST;
      cal_reg[CSR_P_POS] = P_POS_RST;
      cal_reg[CSR_STEP]  = STEP_RST;
      h_pw = H_CTR_RST;
      h_pw_target = H_CTR_RST;
      p_pw = P_CTR_RST;
      p_pw_target = P_CTR_RST;
      h_now = 0;
      p_now = 0;
      h_goal = 0;
      p_goal = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 30;
      rcv_idle_pct = 62;
      test_directed_edges();
      test_default_calibration();
      test_extreme_calibration();

      send_idle_pct = 62;
      rcv_idle_pct = 30;
      test_reversed_calibration();
      test_step_sizes();

      send_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_calibration();
      test_unused_register_index();

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_two_axis_servo_slew_controller_core OK");
      end else begin
         $display("tb_two_axis_servo_slew_controller_core NOT OK");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb_two_axis_servo_slew_controller_core NOT OK");
      $finish;
   end

endmodule
